### hw/rtl/rhsv_pkg.sv
// ----------------------------------------------------------------------------
// rhsv_pkg
// Shared types and constants for the RGB to HSV converter.
// ----------------------------------------------------------------------------
package rhsv_pkg;

  localparam int ChanW              = 8;
  localparam int HueW               = 15;
  localparam int HueFracBitsDefault = 6;

  // one divider lane: partial remainder and divisor
  typedef struct packed {
    logic [ChanW-1:0] rem;
    logic [ChanW-1:0] div;
  } rhsv_div_t;

endpackage

### hw/rtl/rhsv_if.sv
// ----------------------------------------------------------------------------
// rhsv_in_if / rhsv_out_if
// Valid/ready channels for RGB pixel items and HSV result items.
// ----------------------------------------------------------------------------
interface rhsv_in_if;
  logic                        valid;
  logic                        ready;
  logic [rhsv_pkg::ChanW-1:0]  red;
  logic [rhsv_pkg::ChanW-1:0]  green;
  logic [rhsv_pkg::ChanW-1:0]  blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

interface rhsv_out_if;
  logic                        valid;
  logic                        ready;
  logic [rhsv_pkg::HueW-1:0]   hue;
  logic [rhsv_pkg::ChanW-1:0]  saturation;
  logic [rhsv_pkg::ChanW-1:0]  brightness;

  modport source (output valid, output hue, output saturation, output brightness,
                  input ready);
  modport sink   (input valid, input hue, input saturation, input brightness,
                  output ready);
endinterface

### hw/rtl/rgb_to_hsv_converter_top.sv
// ----------------------------------------------------------------------------
// rgb_to_hsv_converter_top
// RGB pixel to fixed-point HSV, one pixel per clock while out_o is not stalled.
// ----------------------------------------------------------------------------
// in_i carries red/green/blue items, out_o carries hue/saturation/brightness
// items, both valid/ready. Hue is in 1/2^HueFracBits degree units (15 bits).
// A front stage finds max/min and forms both dividends; a row of
// $clog2(360 << HueFracBits) division cells (15 for the default) then
// produces one quotient bit of hue and of saturation per cell.
// Throughput: one item per cycle while out_o.ready is high.
// Each stage advances when it is empty or the stage after it advances, so
// a stalled receiver only holds the items behind it; bubbles keep being
// filled and in_i.ready stays high while any stage is free.
// Reset clears all stage valid bits; no item is in flight afterward.
// ----------------------------------------------------------------------------
module rgb_to_hsv_converter_top #(
  parameter int HueFracBits = rhsv_pkg::HueFracBitsDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  rhsv_in_if.sink   in_i,
  rhsv_out_if.source out_o
);

  localparam int HueQw     = $clog2(360 << HueFracBits);
  localparam int NumStages = HueQw + 1;

  logic [NumStages-1:0]       vld;
  logic [NumStages:0]         rdy;
  rhsv_pkg::rhsv_div_t        hue_dv [NumStages];
  rhsv_pkg::rhsv_div_t        sat_dv [NumStages];
  logic [HueQw-1:0]           hue_sh [NumStages];
  logic [HueQw-1:0]           sat_sh [NumStages];
  logic [rhsv_pkg::ChanW-1:0] bright [NumStages];

  assign rdy[NumStages] = out_o.ready;

  for (genvar k = 0; k < NumStages; k++) begin : g_rdy
    assign rdy[k] = !vld[k] || rdy[k+1];
  end

  rhsv_front #(
    .HueFracBits (HueFracBits)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (rdy[0]),
    .valid_i  (in_i.valid),
    .red_i    (in_i.red),
    .green_i  (in_i.green),
    .blue_i   (in_i.blue),
    .valid_o  (vld[0]),
    .hue_dv_o (hue_dv[0]),
    .hue_sh_o (hue_sh[0]),
    .sat_dv_o (sat_dv[0]),
    .sat_sh_o (sat_sh[0]),
    .bright_o (bright[0])
  );

  for (genvar k = 1; k < NumStages; k++) begin : g_cell
    rhsv_div_cell #(
      .Qw (HueQw)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .en_i     (rdy[k]),
      .valid_i  (vld[k-1]),
      .hue_dv_i (hue_dv[k-1]),
      .hue_sh_i (hue_sh[k-1]),
      .sat_dv_i (sat_dv[k-1]),
      .sat_sh_i (sat_sh[k-1]),
      .bright_i (bright[k-1]),
      .valid_o  (vld[k]),
      .hue_dv_o (hue_dv[k]),
      .hue_sh_o (hue_sh[k]),
      .sat_dv_o (sat_dv[k]),
      .sat_sh_o (sat_sh[k]),
      .bright_o (bright[k])
    );
  end

  assign in_i.ready       = rdy[0];
  assign out_o.valid      = vld[NumStages-1];
  assign out_o.hue        = rhsv_pkg::HueW'(hue_sh[NumStages-1]);
  assign out_o.saturation = sat_sh[NumStages-1][rhsv_pkg::ChanW-1:0];
  assign out_o.brightness = bright[NumStages-1];

endmodule

### hw/rtl/rhsv_front.sv
// ----------------------------------------------------------------------------
// rhsv_front
// Max/min, hue sector numerator and divider operands for one pixel.
// ----------------------------------------------------------------------------
module rhsv_front #(
  parameter int HueFracBits = rhsv_pkg::HueFracBitsDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         valid_i,
  input  logic [rhsv_pkg::ChanW-1:0]   red_i,
  input  logic [rhsv_pkg::ChanW-1:0]   green_i,
  input  logic [rhsv_pkg::ChanW-1:0]   blue_i,
  output logic                         valid_o,
  output rhsv_pkg::rhsv_div_t          hue_dv_o,
  output logic [$clog2(360 << HueFracBits)-1:0] hue_sh_o,
  output rhsv_pkg::rhsv_div_t          sat_dv_o,
  output logic [$clog2(360 << HueFracBits)-1:0] sat_sh_o,
  output logic [rhsv_pkg::ChanW-1:0]   bright_o
);

  localparam int HueQw    = $clog2(360 << HueFracBits);
  localparam int DivW     = HueQw + rhsv_pkg::ChanW;
  localparam int HueScale = 60 << HueFracBits;
  localparam int NumW     = 11;

  logic [rhsv_pkg::ChanW-1:0] mx, mn, d;
  logic [NumW-1:0]            n;
  logic [DivW-1:0]            hue_num, sat_num;

  logic                       valid_q;
  rhsv_pkg::rhsv_div_t        hue_dv_q, sat_dv_q;
  logic [HueQw-1:0]           hue_sh_q, sat_sh_q;
  logic [rhsv_pkg::ChanW-1:0] bright_q;

  always_comb begin
    mx = red_i;
    mn = red_i;
    if (green_i > mx) mx = green_i;
    if (blue_i > mx) mx = blue_i;
    if (green_i < mn) mn = green_i;
    if (blue_i < mn) mn = blue_i;
    d = mx - mn;

    // modular 11-bit arithmetic; true value always lies in [0, 6d)
    priority if (mx == red_i) begin
      n = NumW'(green_i) - NumW'(blue_i);
      if (green_i < blue_i) n = n + NumW'(6 * d);
    end else if (mx == green_i) begin
      n = NumW'(2 * d) + NumW'(blue_i) - NumW'(red_i);
    end else begin
      n = NumW'(4 * d) + NumW'(red_i) - NumW'(green_i);
    end

    hue_num = (d == '0) ? '0 : DivW'(n) * DivW'(HueScale);
    sat_num = DivW'({d, 8'h00}) - DivW'(d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hue_dv_q.rem <= hue_num[DivW-1:HueQw];
      hue_dv_q.div <= (d == '0) ? 8'd1 : d;
      hue_sh_q     <= hue_num[HueQw-1:0];
      sat_dv_q.rem <= sat_num[DivW-1:HueQw];
      sat_dv_q.div <= (mx == '0) ? 8'd1 : mx;
      sat_sh_q     <= sat_num[HueQw-1:0];
      bright_q     <= mx;
    end
  end

  assign valid_o  = valid_q;
  assign hue_dv_o = hue_dv_q;
  assign hue_sh_o = hue_sh_q;
  assign sat_dv_o = sat_dv_q;
  assign sat_sh_o = sat_sh_q;
  assign bright_o = bright_q;

endmodule

### hw/rtl/rhsv_div_cell.sv
// ----------------------------------------------------------------------------
// rhsv_div_cell
// One restoring-division step for the hue and saturation lanes.
// ----------------------------------------------------------------------------
module rhsv_div_cell #(
  parameter int Qw = 15
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         valid_i,
  input  rhsv_pkg::rhsv_div_t          hue_dv_i,
  input  logic [Qw-1:0]                hue_sh_i,
  input  rhsv_pkg::rhsv_div_t          sat_dv_i,
  input  logic [Qw-1:0]                sat_sh_i,
  input  logic [rhsv_pkg::ChanW-1:0]   bright_i,
  output logic                         valid_o,
  output rhsv_pkg::rhsv_div_t          hue_dv_o,
  output logic [Qw-1:0]                hue_sh_o,
  output rhsv_pkg::rhsv_div_t          sat_dv_o,
  output logic [Qw-1:0]                sat_sh_o,
  output logic [rhsv_pkg::ChanW-1:0]   bright_o
);

  localparam int W = rhsv_pkg::ChanW;

  logic [W:0]          hue_t, sat_t;
  logic                hue_ge, sat_ge;
  rhsv_pkg::rhsv_div_t hue_dv_d, sat_dv_d;

  logic                valid_q;
  rhsv_pkg::rhsv_div_t hue_dv_q, sat_dv_q;
  logic [Qw-1:0]       hue_sh_q, sat_sh_q;
  logic [W-1:0]        bright_q;

  always_comb begin
    hue_t  = {hue_dv_i.rem, hue_sh_i[Qw-1]};
    sat_t  = {sat_dv_i.rem, sat_sh_i[Qw-1]};
    hue_ge = hue_t >= {1'b0, hue_dv_i.div};
    sat_ge = sat_t >= {1'b0, sat_dv_i.div};

    hue_dv_d.div = hue_dv_i.div;
    sat_dv_d.div = sat_dv_i.div;
    hue_dv_d.rem = hue_ge ? W'(hue_t - {1'b0, hue_dv_i.div}) : hue_t[W-1:0];
    sat_dv_d.rem = sat_ge ? W'(sat_t - {1'b0, sat_dv_i.div}) : sat_t[W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hue_dv_q <= hue_dv_d;
      sat_dv_q <= sat_dv_d;
      hue_sh_q <= {hue_sh_i[Qw-2:0], hue_ge};
      sat_sh_q <= {sat_sh_i[Qw-2:0], sat_ge};
      bright_q <= bright_i;
    end
  end

  assign valid_o  = valid_q;
  assign hue_dv_o = hue_dv_q;
  assign hue_sh_o = hue_sh_q;
  assign sat_dv_o = sat_dv_q;
  assign sat_sh_o = sat_sh_q;
  assign bright_o = bright_q;

endmodule

### hw/rtl/rhsv_checker.sv
// ----------------------------------------------------------------------------
// rhsv_checker
// Port-level checks on the converter's result channel.
// ----------------------------------------------------------------------------
module rhsv_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        out_valid_i,
  input logic                        out_ready_i,
  input logic [rhsv_pkg::HueW-1:0]   hue_i,
  input logic [rhsv_pkg::ChanW-1:0]  saturation_i,
  input logic [rhsv_pkg::ChanW-1:0]  brightness_i
);

  // no result item can be pending while in reset
  a_rst_idle: assert property (@(posedge clk_i) !rst_ni |-> !out_valid_i)
    else $error("result valid during reset");

  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result item dropped while stalled");

  a_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      $stable(hue_i) && $stable(saturation_i) && $stable(brightness_i))
    else $error("stalled result item changed");

  // zero saturation only for grey, and grey has hue zero
  a_grey_hue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && saturation_i == '0 |-> hue_i == '0)
    else $error("grey item with nonzero hue");

endmodule

bind rgb_to_hsv_converter_top rhsv_checker u_rhsv_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .hue_i        (out_o.hue),
  .saturation_i (out_o.saturation),
  .brightness_i (out_o.brightness)
);
